FILE: design/wbp_pkg.sv
// Shared types, constants and the base64 alphabet for the word base64 packer.
package wbp_pkg;

  localparam int unsigned SymBits  = 6;
  localparam int unsigned SymCount = 16;
  localparam int unsigned WordBits = 32;
  localparam int unsigned CharBits = 7;

  // The full stream of one group: sixteen 6-bit symbols, symbol 0 in the low bits.
  typedef logic [SymCount-1:0][SymBits-1:0] stream_t;
  typedef logic [$clog2(SymCount)-1:0]      sym_idx_t;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_FLUSH  = 1'b1
  } cmd_e;

  // Words already held in the group being built.
  localparam logic [1:0] PHASE_EMPTY = 2'd0;
  localparam logic [1:0] PHASE_ONE   = 2'd1;
  localparam logic [1:0] PHASE_TWO   = 2'd2;

  // Index of the final symbol of a run.
  localparam sym_idx_t LAST_IDX_ONE  = sym_idx_t'(5);
  localparam sym_idx_t LAST_IDX_TWO  = sym_idx_t'(10);
  localparam sym_idx_t LAST_IDX_FULL = sym_idx_t'(SymCount - 1);

  // A finished group waiting for the serializer.
  typedef struct packed {
    logic     vld;
    stream_t  stream;
    sym_idx_t last_idx;
  } group_t;

  // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [CharBits-1:0] b64_char(input logic [SymBits-1:0] sym);
    logic [CharBits-1:0] s;
    logic [CharBits-1:0] c;
    s = {1'b0, sym};
    if (sym < 6'd26) begin
      c = s + 7'd65;
    end else if (sym < 6'd52) begin
      c = s + 7'd71;
    end else if (sym < 6'd62) begin
      c = s - 7'd4;
    end else if (sym == 6'd62) begin
      c = 7'd43;
    end else begin
      c = 7'd47;
    end
    return c;
  endfunction

endpackage

FILE: design/wbp_if.sv
// Valid/ready channel interfaces for input words and output characters.
interface wbp_in_if;
  import wbp_pkg::*;
  logic                valid;
  logic                ready;
  logic                command;
  logic [WordBits-1:0] data_word;

  modport source (output valid, output command, output data_word, input ready);
  modport sink   (input valid, input command, input data_word, output ready);
endinterface

interface wbp_out_if;
  import wbp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CharBits-1:0] symbol_char;
  logic                last_char;

  modport source (output valid, output symbol_char, output last_char, input ready);
  modport sink   (input valid, input symbol_char, input last_char, output ready);
endinterface

FILE: design/wbp_packer.sv
// Group builder: byte-swaps words, collects the bit stream and hands off finished groups.
module wbp_packer import wbp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  wbp_in_if.sink         in_i,
  input  logic           grp_take_i,
  output group_t         grp_o
);

  logic [2*WordBits-1:0] stream_q, stream_d;
  logic [1:0]            phase_q, phase_d;
  logic                  grp_vld_q, grp_vld_d;
  stream_t               grp_stream_q, grp_stream_d;
  sym_idx_t              grp_last_q, grp_last_d;
  logic [WordBits-1:0]   swapped;
  logic                  accept;

  // The slot frees up in the same cycle the serializer takes it.
  assign in_i.ready = !grp_vld_q || grp_take_i;
  assign accept     = in_i.valid && in_i.ready;
  assign swapped    = {in_i.data_word[7:0], in_i.data_word[15:8],
                       in_i.data_word[23:16], in_i.data_word[31:24]};

  always_comb begin
    stream_d     = stream_q;
    phase_d      = phase_q;
    grp_vld_d    = grp_vld_q && !grp_take_i;
    grp_stream_d = grp_stream_q;
    grp_last_d   = grp_last_q;
    if (accept) begin
      if (in_i.command == CMD_FLUSH) begin
        if (phase_q != PHASE_EMPTY) begin
          grp_vld_d    = 1'b1;
          grp_stream_d = stream_t'({{WordBits{1'b0}}, stream_q});
          grp_last_d   = (phase_q == PHASE_ONE) ? LAST_IDX_ONE : LAST_IDX_TWO;
          stream_d     = '0;
          phase_d      = PHASE_EMPTY;
        end
      end else begin
        unique case (phase_q)
          PHASE_EMPTY: begin
            stream_d[WordBits-1:0] = swapped;
            phase_d                = PHASE_ONE;
          end
          PHASE_ONE: begin
            stream_d[2*WordBits-1:WordBits] = swapped;
            phase_d                         = PHASE_TWO;
          end
          default: begin
            grp_vld_d    = 1'b1;
            grp_stream_d = stream_t'({swapped, stream_q});
            grp_last_d   = LAST_IDX_FULL;
            stream_d     = '0;
            phase_d      = PHASE_EMPTY;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_q  <= '0;
      phase_q   <= PHASE_EMPTY;
      grp_vld_q <= 1'b0;
    end else begin
      stream_q  <= stream_d;
      phase_q   <= phase_d;
      grp_vld_q <= grp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_stream_q <= grp_stream_d;
    grp_last_q   <= grp_last_d;
  end

  assign grp_o.vld      = grp_vld_q;
  assign grp_o.stream   = grp_stream_q;
  assign grp_o.last_idx = grp_last_q;

endmodule

FILE: design/wbp_serializer.sv
// Character serializer: walks a finished group into the output register, one symbol a cycle unless stalled.
module wbp_serializer import wbp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  group_t         grp_i,
  output logic           grp_take_o,
  wbp_out_if.source      out_o
);

  logic                busy_q, busy_d;
  stream_t             stream_q;
  sym_idx_t            idx_q, idx_d;
  sym_idx_t            last_q;
  logic                ov_q, ov_d;
  logic [CharBits-1:0] oc_q, oc_d;
  logic                ol_q, ol_d;
  logic                out_adv;
  logic                emit;
  logic                at_last;

  assign out_adv    = !ov_q || out_o.ready;
  assign emit       = busy_q && out_adv;
  assign at_last    = (idx_q == last_q);
  assign grp_take_o = grp_i.vld && (!busy_q || (emit && at_last));

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    ov_d   = ov_q && !out_o.ready;
    oc_d   = oc_q;
    ol_d   = ol_q;
    if (emit) begin
      ov_d = 1'b1;
      oc_d = b64_char(stream_q[idx_q]);
      ol_d = at_last;
      idx_d = idx_q + sym_idx_t'(1);
      if (at_last) begin
        busy_d = 1'b0;
      end
    end
    if (grp_take_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    oc_q  <= oc_d;
    ol_q  <= ol_d;
    if (grp_take_o) begin
      stream_q <= grp_i.stream;
      last_q   <= grp_i.last_idx;
    end
  end

  assign out_o.valid       = ov_q;
  assign out_o.symbol_char = oc_q;
  assign out_o.last_char   = ol_q;

endmodule

FILE: design/word_base64_packer_top.sv
// Top level of the word base64 packer: group builder feeding a character serializer.
//
// The block takes one word per cycle while its input is ready: a 32-bit data word
// (byte-swapped on entry) or a flush command. Data words are packed least significant
// bit first into a 96-bit group; the first two words of a group produce no characters,
// the third releases all sixteen base64 characters, and a flush releases the five or
// ten characters of a partial group plus one more, or nothing when no word is held.
// Characters leave one per cycle while the output is ready, from a registered output,
// with last_char marking the final character of each run; the single-character output
// port sets the sustained rate. One finished group can wait in a slot while the
// previous group is still being sent; input is stalled only when that slot is occupied
// and not being taken in the same cycle, also for a word that completes a group.
module word_base64_packer_top import wbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  wbp_in_if.sink    in_i,
  wbp_out_if.source out_o
);

  group_t grp;
  logic   grp_take;

  wbp_packer u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .grp_take_i (grp_take),
    .grp_o      (grp)
  );

  wbp_serializer u_serializer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grp_i      (grp),
    .grp_take_o (grp_take),
    .out_o      (out_o)
  );

  // Input stalls only while a finished group sits in the slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_i.ready |-> grp.vld)
    else $error("input stalled with an empty group slot");

  // A waiting group carries a run length of one partial or one full group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp.vld |-> (grp.last_idx == LAST_IDX_ONE || grp.last_idx == LAST_IDX_TWO ||
                 grp.last_idx == LAST_IDX_FULL))
    else $error("group slot holds an impossible run length");

  // A group that is not taken stays in the slot unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp.vld && !grp_take |=> grp.vld && $stable(grp.stream) && $stable(grp.last_idx))
    else $error("waiting group lost or changed");

endmodule
